@@ hdl/rsbh_pkg.sv @@
`timescale 1ns / 1ps
package rsbh_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  localparam int AXES = 3;

endpackage

@@ hdl/ray_segment_box_hit_test.sv @@
`timescale 1ns / 1ps
// channel   | handshake              | payload
// ----------+------------------------+------------------------------------
// input     | start / busy           | in_start_[xyz], in_end_[xyz]
// result    | out_valid (strobe)     | out_hit
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat enters every cycle; busy is never raised. The pipeline depth is
// set by the restoring divider, one quotient bit per stage. Reset clears
// the valid bits and the box to zero. The receiver cannot stall, so the
// pipeline never holds.
module ray_segment_box_hit_test
  import rsbh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_start_z,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [COORD_BITS-1:0]   in_end_z,
  output logic                    out_valid,
  output logic                    out_hit,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int TW = F + 1;
  localparam int H  = C / 2;
  localparam int L  = C - H;
  localparam int LAT = F + 6;

  logic [C-1:0] box_lo_r [AXES];
  logic [C-1:0] box_hi_r [AXES];
  logic [C-1:0] lo_b [AXES];
  logic [C-1:0] hi_b [AXES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_X: box_lo_r[0] <= cfg_data;
        REG_MIN_Y: box_lo_r[1] <= cfg_data;
        REG_MIN_Z: box_lo_r[2] <= cfg_data;
        REG_MAX_X: box_hi_r[0] <= cfg_data;
        REG_MAX_Y: box_hi_r[1] <= cfg_data;
        REG_MAX_Z: box_hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // flip the sign bit so unsigned compares keep signed order
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      lo_b[a] = {~box_lo_r[a][C-1], box_lo_r[a][C-2:0]};
      hi_b[a] = {~box_hi_r[a][C-1], box_hi_r[a][C-2:0]};
    end
  end

  // ---- input register
  logic         va_r;
  logic [C-1:0] sa_r [AXES];
  logic [C-1:0] ea_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= start && !busy;
    sa_r[0] <= {~in_start_x[C-1], in_start_x[C-2:0]};
    sa_r[1] <= {~in_start_y[C-1], in_start_y[C-2:0]};
    sa_r[2] <= {~in_start_z[C-1], in_start_z[C-2:0]};
    ea_r[0] <= {~in_end_x[C-1], in_end_x[C-2:0]};
    ea_r[1] <= {~in_end_y[C-1], in_end_y[C-2:0]};
    ea_r[2] <= {~in_end_z[C-1], in_end_z[C-2:0]};
  end

  // ---- classify, then divider stages 0..F
  logic            dv_r   [0:F];
  logic            rej_r  [0:F];
  logic [AXES-1:0] has_r  [0:F];
  logic [AXES-1:0] sat_r  [0:F];
  logic [C-1:0]    rem_r  [0:F][AXES];
  logic [C-1:0]    den_r  [0:F][AXES];
  logic [F-1:0]    q_r    [0:F][AXES];
  logic [C-1:0]    s_r    [0:F][AXES];
  logic [C-1:0]    e_r    [0:F][AXES];

  logic            rej_nxt;
  logic [AXES-1:0] has_nxt;
  logic [AXES-1:0] sat_nxt;
  logic [C-1:0]    num_nxt [AXES];
  logic [C-1:0]    den_nxt [AXES];

  always_comb begin
    logic below, above;
    rej_nxt = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      below = sa_r[a] < lo_b[a];
      above = !below && (sa_r[a] > hi_b[a]);
      if ((below && ea_r[a] < lo_b[a]) || (above && ea_r[a] > hi_b[a])) rej_nxt = 1'b1;
      has_nxt[a] = below || above;
      num_nxt[a] = below ? lo_b[a] - sa_r[a] : sa_r[a] - hi_b[a];
      den_nxt[a] = below ? ea_r[a] - sa_r[a] : sa_r[a] - ea_r[a];
      sat_nxt[a] = num_nxt[a] >= den_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= va_r;
    rej_r[0] <= rej_nxt;
    has_r[0] <= has_nxt;
    sat_r[0] <= sat_nxt;
    for (int a = 0; a < AXES; a++) begin
      rem_r[0][a] <= num_nxt[a];
      den_r[0][a] <= den_nxt[a];
      q_r[0][a]   <= '0;
      s_r[0][a]   <= sa_r[a];
      e_r[0][a]   <= ea_r[a];
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [C:0] two_r [AXES];
    logic       bit_q [AXES];

    // rem < den holds once saturation is ruled out, so 2*rem fits C+1 bits
    always_comb begin
      for (int a = 0; a < AXES; a++) begin
        two_r[a] = {rem_r[k][a], 1'b0};
        bit_q[a] = two_r[a] >= {1'b0, den_r[k][a]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      rej_r[k+1] <= rej_r[k];
      has_r[k+1] <= has_r[k];
      sat_r[k+1] <= sat_r[k];
      for (int a = 0; a < AXES; a++) begin
        rem_r[k+1][a] <= bit_q[a] ? C'(two_r[a] - {1'b0, den_r[k][a]}) : two_r[a][C-1:0];
        den_r[k+1][a] <= den_r[k][a];
        q_r[k+1][a]   <= {q_r[k][a][F-2:0], bit_q[a]};
        s_r[k+1][a]   <= s_r[k][a];
        e_r[k+1][a]   <= e_r[k][a];
      end
    end
  end

  // ---- entry plane select
  logic            vb_r, rejb_r, noneb_r;
  logic [AXES-1:0] selb_r;
  logic [TW-1:0]   tb_r;
  logic [C-1:0]    sb_r  [AXES];
  logic [C-1:0]    db_r  [AXES];
  logic [AXES-1:0] negb_r;

  logic [AXES-1:0] sel_nxt;
  logic [TW-1:0]   bt_nxt;
  logic            found_nxt;

  always_comb begin
    logic [TW-1:0] ta;
    sel_nxt   = '0;
    bt_nxt    = '0;
    found_nxt = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      ta = sat_r[F][a] ? TW'(1) << F : {1'b0, q_r[F][a]};
      // strict compare keeps the earlier axis on a tie
      if (has_r[F][a] && (!found_nxt || ta > bt_nxt)) begin
        sel_nxt   = AXES'(1) << a;
        bt_nxt    = ta;
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= dv_r[F];
    rejb_r  <= rej_r[F];
    noneb_r <= !found_nxt;
    selb_r  <= sel_nxt;
    tb_r    <= bt_nxt;
    for (int a = 0; a < AXES; a++) begin
      negb_r[a] <= e_r[F][a] < s_r[F][a];
      db_r[a]   <= (e_r[F][a] < s_r[F][a]) ? s_r[F][a] - e_r[F][a]
                                           : e_r[F][a] - s_r[F][a];
      sb_r[a]   <= s_r[F][a];
    end
  end

  // ---- partial products of |delta| * t
  logic            vc_r, rejc_r, nonec_r;
  logic [AXES-1:0] selc_r, negc_r;
  logic [C-1:0]    sc_r   [AXES];
  logic [L+TW-1:0] pplo_r [AXES];
  logic [H+TW-1:0] pphi_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
    rejc_r  <= rejb_r;
    nonec_r <= noneb_r;
    selc_r  <= selb_r;
    negc_r  <= negb_r;
    for (int a = 0; a < AXES; a++) begin
      sc_r[a]   <= sb_r[a];
      pplo_r[a] <= {{TW{1'b0}}, db_r[a][L-1:0]} * {{L{1'b0}}, tb_r};
      pphi_r[a] <= {{TW{1'b0}}, db_r[a][C-1:L]} * {{H{1'b0}}, tb_r};
    end
  end

  // ---- entry point check
  logic            vd_r, rejd_r, noned_r;
  logic [AXES-1:0] okd_r;

  logic [AXES-1:0] ok_nxt;
  always_comb begin
    logic [C+TW-1:0] prod;
    logic [C:0]      m, p;
    for (int a = 0; a < AXES; a++) begin
      prod = (C+TW)'(pplo_r[a]) + ((C+TW)'(pphi_r[a]) << L);
      m    = prod[C+F:F];
      p    = negc_r[a] ? {1'b0, sc_r[a]} - m : {1'b0, sc_r[a]} + m;
      ok_nxt[a] = selc_r[a] || (p >= {1'b0, lo_b[a]} && p <= {1'b0, hi_b[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
    rejd_r  <= rejc_r;
    noned_r <= nonec_r;
    okd_r   <= ok_nxt;
  end

  // ---- result register
  logic out_vld_r, out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= vd_r;
    out_hit_r <= !rejd_r && (noned_r || (&okd_r));
  end

  assign out_valid = out_vld_r;
  assign out_hit   = out_hit_r;

  // ---- assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input beat");

  a_sel_one: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (noneb_r ? (selb_r == '0) : $onehot(selb_r)))
    else $error("entry plane select not one-hot");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && rejd_r |=> out_valid && !out_hit)
    else $error("rejected segment reported as hit");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rsbh_pkg::*;

  localparam int LATENCY = FRAC_BITS_DEF + 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_B = 3'd7;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic [2:0][31:0] p0;
    logic [2:0][31:0] p1;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic [31:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_valid, out_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ray_segment_box_hit_test DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .out_valid(out_valid), .out_hit(out_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  segment_t pending_segs[$];
  bit hit_expect_q[$];
  logic [2:0][31:0] box_lo = '0;   // as last written to the block
  logic [2:0][31:0] box_hi = '0;
  int errors = 0;
  int cycles = 0;
  bit took = 0;
  bit hold = 0;
  bit no_gaps = 0;
  int gap = 0;

  // signed to order-preserving unsigned
  function automatic logic [63:0] biased(logic [31:0] v);
    return {32'd0, v ^ MOST_NEG};
  endfunction

  function automatic bit predict_hit(segment_t sg);
    logic [63:0] lo, hi, s, e, t, best_t, p, d, num, den, q, r;
    int best;
    bit hit;
    best = -1;
    best_t = 0;
    hit = 1;
    for (int a = 0; a < 3; a++) begin
      if (hit) begin
        lo = biased(box_lo[a]);
        hi = biased(box_hi[a]);
        s = biased(sg.p0[a]);
        e = biased(sg.p1[a]);
        num = 0;
        den = 0;
        if (s < lo) begin
          if (e < lo) hit = 0;
          else begin
            num = lo - s;
            den = e - s;
          end
        end else if (s > hi) begin
          if (e > hi) hit = 0;
          else begin
            num = s - hi;
            den = s - e;
          end
        end
        if (hit && den != 0) begin
          if (num >= den) t = 64'd1 << FRAC_BITS_DEF;
          else begin
            q = 0;
            r = num;
            for (int i = 0; i < FRAC_BITS_DEF; i++) begin
              q = q << 1;
              if (r >= den - r) begin
                r = r - (den - r);
                q = q | 64'd1;
              end else begin
                r = r + r;
              end
            end
            t = q;
          end
          // ties keep the earlier axis
          if (best < 0 || t > best_t) begin
            best = a;
            best_t = t;
          end
        end
      end
    end
    if (hit && best >= 0) begin
      for (int a = 0; a < 3; a++) begin
        if (a != best && hit) begin
          s = biased(sg.p0[a]);
          e = biased(sg.p1[a]);
          if (e >= s) begin
            d = e - s;
            p = s + ((d * best_t) >> FRAC_BITS_DEF);
          end else begin
            d = s - e;
            p = s - ((d * best_t) >> FRAC_BITS_DEF);
          end
          if (p < biased(box_lo[a]) || p > biased(box_hi[a])) hit = 0;
        end
      end
    end
    return hit;
  endfunction

  // driver: one beat per item, random gaps between beats unless no_gaps is set
  always @(negedge clk) begin
    bit nstart;
    segment_t sg;
    nstart = 0;
    sg = '0;
    if (rst_n) begin
      if (took) begin
        void'(pending_segs.pop_front());
        took = 0;
        if (no_gaps) gap = 0;
        else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(10, 40);
          endcase
        end
      end
      if (gap > 0) gap--;
      else if (pending_segs.size() > 0 && !hold) begin
        nstart = 1;
        sg = pending_segs[0];
      end
      start <= nstart;
      if (nstart) begin
        in_start_x <= sg.p0[0];
        in_start_y <= sg.p0[1];
        in_start_z <= sg.p0[2];
        in_end_x <= sg.p1[0];
        in_end_y <= sg.p1[1];
        in_end_z <= sg.p1[2];
      end
    end
  end

  // monitor: predict on accepted beats, check results, track box writes
  always @(posedge clk) begin
    segment_t sg;
    bit want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (hit_expect_q.size() == 0) begin
          $error("hit: unexpected result, actual %0d", out_hit);
          errors++;
        end else begin
          want = hit_expect_q.pop_front();
          if (out_hit !== want) begin
            $error("hit: expected %0d actual %0d", want, out_hit);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        sg.p0 = {in_start_z, in_start_y, in_start_x};
        sg.p1 = {in_end_z, in_end_y, in_end_x};
        hit_expect_q.push_back(predict_hit(sg));
        took = 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_X: box_lo[0] <= cfg_data;
          REG_MIN_Y: box_lo[1] <= cfg_data;
          REG_MIN_Z: box_lo[2] <= cfg_data;
          REG_MAX_X: box_hi[0] <= cfg_data;
          REG_MAX_Y: box_hi[1] <= cfg_data;
          REG_MAX_Z: box_hi[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_segs.size() > 0 || hit_expect_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_box(logic [2:0][31:0] lo, logic [2:0][31:0] hi);
    drain();
    cfg_write(REG_MIN_X, lo[0]);
    cfg_write(REG_MIN_Y, lo[1]);
    cfg_write(REG_MIN_Z, lo[2]);
    cfg_write(REG_MAX_X, hi[0]);
    cfg_write(REG_MAX_Y, hi[1]);
    cfg_write(REG_MAX_Z, hi[2]);
    // spare indexes must be ignored
    cfg_write($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // coordinate near the box on one axis, or anywhere
  function automatic logic [31:0] pick_coord(int a);
    case ($urandom_range(0, 9))
      0: return box_lo[a];
      1: return box_hi[a];
      2: return box_lo[a] - $urandom_range(1, 4 * ONE);
      3: return box_hi[a] + $urandom_range(1, 4 * ONE);
      4: return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
      5: return $urandom;
      default: return box_lo[a] + (box_hi[a] - box_lo[a]) / 2 + $urandom_range(0, 8 * ONE)
                      - 4 * ONE;
    endcase
  endfunction

  task automatic add_random(int n);
    segment_t sg;
    for (int k = 0; k < n; k++) begin
      for (int a = 0; a < 3; a++) begin
        sg.p0[a] = pick_coord(a);
        sg.p1[a] = pick_coord(a);
      end
      pending_segs.push_back(sg);
    end
  endtask

  task automatic add_seg(logic [31:0] sx, sy, sz, ex, ey, ez);
    segment_t sg;
    sg.p0 = {sz, sy, sx};
    sg.p1 = {ez, ey, ex};
    pending_segs.push_back(sg);
  endtask

  initial begin
    logic [2:0][31:0] lo, hi;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset box is a single point at the origin
    add_seg(0, 0, 0, 0, 0, 0);
    add_seg(MOST_NEG, 0, 0, MOST_POS, 0, 0);
    add_seg(ONE, ONE, ONE, 2 * ONE, ONE, ONE);
    add_random(10);

    lo = {-32'sd2 * ONE, -32'sd2 * ONE, -32'sd2 * ONE};
    hi = {2 * ONE, 2 * ONE, 2 * ONE};
    set_box(lo, hi);
    add_seg(0, 0, 0, 5 * ONE, 5 * ONE, 5 * ONE);                     // start inside
    add_seg(-32'sd5 * ONE, 0, 0, -32'sd3 * ONE, 0, 0);               // both below
    add_seg(5 * ONE, 0, 0, 3 * ONE, 0, 0);                           // both above
    add_seg(-32'sd4 * ONE, -32'sd4 * ONE, 0, 4 * ONE, 4 * ONE, 0);  // tie x/y
    add_seg(-32'sd2 * ONE, 2 * ONE, 0, -32'sd2 * ONE, 2 * ONE, 0);  // on bounds
    add_seg(-32'sd3 * ONE, 3 * ONE, 0, 3 * ONE, 3 * ONE, 0);        // passes over
    add_seg(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
    add_seg(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG);
    add_seg(0, MOST_POS, 0, 0, -32'sd2 * ONE, 0);
    add_seg(MOST_NEG, 0, 0, -32'sd2 * ONE, 0, 0);                    // t exactly one

    // pause mid-stream until every issued beat has its result, then go on
    repeat (12) @(negedge clk);
    hold = 1;
    @(negedge clk);
    while (hit_expect_q.size() > 0) @(negedge clk);
    hold = 0;
    drain();
    no_gaps = 1;
    add_random(150);
    drain();
    no_gaps = 0;
    add_random(150);

    set_box({MOST_NEG, MOST_NEG, MOST_NEG}, {MOST_POS, MOST_POS, MOST_POS});
    add_random(100);

    // inverted box
    set_box({ONE, ONE, ONE}, {-32'sd1 * ONE, -32'sd1 * ONE, -32'sd1 * ONE});
    add_random(100);

    set_box({MOST_POS, MOST_POS, MOST_POS}, {MOST_NEG, MOST_NEG, MOST_NEG});
    add_random(50);

    for (int ph = 0; ph < 5; ph++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = $urandom;
        hi[a] = ($urandom_range(0, 3) == 0) ? $urandom : lo[a] + $urandom_range(1, 2 ** 30);
        if ($signed(hi[a]) < $signed(lo[a]) && $urandom_range(0, 1)) hi[a] = MOST_POS;
      end
      set_box(lo, hi);
      add_random(120);
    end

    drain();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ ray_segment_box_hit_test.f @@
hdl/rsbh_pkg.sv
hdl/ray_segment_box_hit_test.sv
tb/tb_top.sv
